[hdl/assert_macros.svh]
// assertion macros used by the back end rtl file (dsh_back)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rstn, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rstn, prop, msg)
`define ASSERT_NEVER(label, clk, rstn, expr, msg)
`endif
`endif

[hdl/dsh_pkg.sv]
// types and constants of the dyno speed hold unit
`timescale 1ns / 1ps
package dsh_pkg;
    typedef struct packed {
        logic               req_type;
        logic [19:0]        speed;
        logic signed [15:0] torque;
        logic               cycle_done;
    } dsh_in_t;

    typedef struct packed {
        logic signed [15:0] brake_command;
        logic               throttle_open;
        logic [1:0]         phase;
        logic               done_res;
        logic [1:0]         status;
        logic [19:0]        final_speed;
        logic signed [15:0] mean_torque;
        logic signed [23:0] power_watts;
        logic [15:0]        spread_ratio;
    } dsh_out_t;

    localparam logic [2:0] REG_TARGET    = 3'd0;
    localparam logic [2:0] REG_OVERSPEED = 3'd1;
    localparam logic [2:0] REG_WINDOW    = 3'd2;
    localparam logic [2:0] REG_GAIN      = 3'd3;
    localparam logic [2:0] REG_TOL       = 3'd4;
    localparam logic [2:0] REG_BLOW      = 3'd5;
    localparam logic [2:0] REG_BHIGH     = 3'd6;

    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_SETTLE  = 2'd1;
    localparam logic [1:0] PH_COLLECT = 2'd2;

    localparam logic [1:0] ST_NONE    = 2'd0;
    localparam logic [1:0] ST_SETTLED = 2'd1;
    localparam logic [1:0] ST_TIMEOUT = 2'd2;
    localparam logic [1:0] ST_NOREAD  = 2'd3;

    localparam logic [20:0] SETTLE_STEPS  = 21'd1500000;
    localparam logic [20:0] COLLECT_STEPS = 21'd400000;
    localparam logic [20:0] POWER_Q32     = 21'd1756906;

    // configuration snapshot handed to the back end
    typedef struct packed {
        logic [19:0]        target_speed;
        logic [19:0]        overspeed_limit;
        logic [15:0]        speed_window;
        logic [9:0]         trim_gain;
        logic [15:0]        settle_tolerance;
        logic signed [15:0] brake_low;
        logic [14:0]        brake_high;
    } dsh_cfg_t;
endpackage

[hdl/dsh_ram.sv]
// generic simple dual port ram with registered read
`timescale 1ns / 1ps
module dsh_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 20
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data <= mem_reg[rd_addr];
    end
endmodule

[hdl/dsh_front.sv]
// front end: accepts beats, registers config and queues work
`timescale 1ns / 1ps
module dsh_front import dsh_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  dsh_in_t     s_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output logic        q_valid,
    input  logic        q_ready,
    output dsh_in_t     q_data,
    output dsh_cfg_t    cfg
);
    // two entry queue
    dsh_in_t    buf_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign s_ready   = cnt_reg != 2'd2;
    assign cfg_ready = 1'b1;
    assign push      = s_valid && s_ready;
    assign pop       = q_valid && q_ready;
    assign q_valid   = cnt_reg != 2'd0;
    assign q_data    = buf_reg[rptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            buf_reg[wptr_reg] <= s_data;
        end
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else begin
            if (push) wptr_reg <= !wptr_reg;
            if (pop)  rptr_reg <= !rptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg.target_speed     <= 20'd16000;
            cfg.overspeed_limit  <= 20'd105600;
            cfg.speed_window     <= 16'd400;
            cfg.trim_gain        <= 10'd154;
            cfg.settle_tolerance <= 16'd262;
            cfg.brake_low        <= -16'sd2400;
            cfg.brake_high       <= 15'd19200;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_TARGET:    cfg.target_speed     <= cfg_data[19:0];
                REG_OVERSPEED: cfg.overspeed_limit  <= cfg_data[19:0];
                REG_WINDOW:    cfg.speed_window     <= cfg_data[15:0];
                REG_GAIN:      cfg.trim_gain        <= cfg_data[9:0];
                REG_TOL:       cfg.settle_tolerance <= cfg_data[15:0];
                REG_BLOW:      cfg.brake_low        <= cfg_data[15:0];
                REG_BHIGH:     cfg.brake_high       <= cfg_data[14:0];
                default: ;
            endcase
        end
    end
endmodule

[hdl/dsh_back.sv]
// back end: control step, settle window, collection and final math
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dsh_back import dsh_pkg::*; #(
    parameter int WINDOW_LEN = 8,
    parameter int READINGS   = 20
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     q_valid,
    output logic     q_ready,
    input  dsh_in_t  q_data,
    input  dsh_cfg_t cfg,
    output logic     m_valid,
    input  logic     m_ready,
    output dsh_out_t m_data
);
    localparam int WW = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int FW = $clog2(WINDOW_LEN + 1);
    localparam int RA = (READINGS > 1) ? $clog2(READINGS) : 1;
    localparam int RC = $clog2(READINGS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_STEP, S_WMIN, S_WTEST, S_SUM, S_DIVSET, S_DIV,
        S_POW1, S_POW2, S_DEV, S_RDIV, S_OUT
    } st_t;

    st_t                 st_reg;
    dsh_in_t             it_reg;
    logic [1:0]          ph_reg;
    logic signed [15:0]  win_reg [WINDOW_LEN];
    logic [WW-1:0]       slot_reg;
    logic [FW-1:0]       fill_reg;
    logic [RC-1:0]       rcnt_reg;
    logic [20:0]         step_reg;
    logic signed [15:0]  last_reg;
    logic                tmo_reg;
    logic [WW-1:0]       widx_reg;
    logic signed [15:0]  lo_reg, hi_reg;
    logic [RC-1:0]       idx_reg;
    logic signed [22:0]  sum_reg;
    logic signed [16:0]  mean_reg;
    logic [22:0]         rem_reg, dvd_reg;
    logic [22:0]         quo_reg;
    logic [4:0]          bit_reg;
    logic                neg_reg;
    logic [36:0]         p_reg;
    logic                pneg_reg;
    logic [57:0]         mag_reg;
    logic [16:0]         dev_reg;
    logic [15:0]         den_reg;
    logic                rd_lag_reg;
    logic                ratio_mode_reg;

    logic                mem_we;
    logic [RA-1:0]       mem_wa, mem_ra;
    logic [15:0]         mem_rd;
    logic signed [15:0]  rd_val;

    // brake arithmetic
    logic signed [21:0]  err;
    logic signed [32:0]  prod;
    logic signed [24:0]  trim, bsum;
    logic signed [15:0]  brake;
    logic [20:0]         steps_next;

    assign err  = $signed({2'b00, it_reg.speed}) - $signed({2'b00, cfg.target_speed});
    assign prod = err * $signed({1'b0, cfg.trim_gain});
    assign trim = prod[32:8];
    assign bsum = trim + 25'(it_reg.torque);
    always_comb begin
        logic signed [24:0] b;
        b = bsum;
        if (b < 25'(cfg.brake_low)) b = 25'(cfg.brake_low);
        if (b > $signed({10'd0, cfg.brake_high})) b = $signed({10'd0, cfg.brake_high});
        brake = b[15:0];
    end
    assign steps_next = step_reg + 21'd1;

    assign rd_val = mem_rd;
    assign mem_we = (st_reg == S_STEP) && (ph_reg == PH_COLLECT) && !it_reg.req_type
                    && it_reg.cycle_done && (rcnt_reg < RC'(READINGS));
    assign mem_wa = rcnt_reg[RA-1:0];
    assign mem_ra = idx_reg[RA-1:0];

    dsh_ram #(.WIDTH(16), .DEPTH(READINGS)) u_store (
        .aclk(aclk), .wr_en(mem_we), .wr_addr(mem_wa), .wr_data(it_reg.torque),
        .rd_addr(mem_ra), .rd_data(mem_rd)
    );

    assign q_ready = (st_reg == S_IDLE) && !m_valid;

    // window spread test
    logic signed [34:0] lhs, rhs;
    logic               still;
    logic [20:0]        serr;
    assign lhs   = 35'($signed({1'b0, 17'(hi_reg - lo_reg)}) <<< 16);
    assign rhs   = $signed({1'b0, cfg.settle_tolerance}) * hi_reg;
    assign still = lhs < rhs;
    assign serr  = (it_reg.speed >= cfg.target_speed) ? 21'(it_reg.speed - cfg.target_speed)
                                                       : 21'(cfg.target_speed - it_reg.speed);

    logic [16:0] absd;
    logic signed [17:0] dsig;
    assign dsig = 18'(rd_val) - 18'(mean_reg);
    assign absd = dsig[17] ? 17'(-dsig) : 17'(dsig);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= S_IDLE;
            ph_reg   <= PH_IDLE;
            slot_reg <= '0;
            fill_reg <= '0;
            rcnt_reg <= '0;
            step_reg <= '0;
            last_reg <= '0;
            tmo_reg  <= 1'b0;
            bit_reg  <= '0;
            m_valid  <= 1'b0;
        end else begin
            if (m_valid && m_ready) m_valid <= 1'b0;
            unique case (st_reg)
                S_IDLE: if (q_valid && q_ready) begin
                    it_reg <= q_data;
                    st_reg <= S_STEP;
                end
                S_STEP: begin
                    dsh_out_t      out_next;
                    st_t           st_next;
                    logic [1:0]    ph_next;
                    logic [20:0]   step_next;
                    logic [RC-1:0] rcnt_next;
                    logic          tmo_next;
                    out_next               = '0;
                    out_next.throttle_open = !(it_reg.speed > cfg.overspeed_limit);
                    out_next.brake_command = last_reg;
                    st_next   = S_OUT;
                    ph_next   = ph_reg;
                    step_next = step_reg;
                    rcnt_next = rcnt_reg;
                    tmo_next  = tmo_reg;
                    if (it_reg.req_type) begin
                        ph_next = PH_SETTLE; step_next = '0; rcnt_next = '0; tmo_next = 1'b0;
                        slot_reg <= '0; fill_reg <= '0;
                    end else if (ph_reg == PH_SETTLE) begin
                        last_reg <= brake;
                        out_next.brake_command = brake;
                        step_next = steps_next;
                        if (it_reg.cycle_done) begin
                            win_reg[slot_reg] <= it_reg.torque;
                            slot_reg <= (32'(slot_reg) + 1 >= WINDOW_LEN) ? '0 : slot_reg + 1'b1;
                            if (fill_reg < FW'(WINDOW_LEN)) fill_reg <= fill_reg + 1'b1;
                        end
                        if (it_reg.cycle_done && (fill_reg + 1'b1 >= FW'(WINDOW_LEN))
                            && (serr <= 21'(cfg.speed_window))) begin
                            widx_reg <= '0;
                            st_next = S_WMIN;
                        end else if (steps_next >= SETTLE_STEPS) begin
                            tmo_next = 1'b1; ph_next = PH_COLLECT;
                            step_next = '0; rcnt_next = '0;
                        end
                    end else if (ph_reg == PH_COLLECT) begin
                        last_reg <= brake;
                        out_next.brake_command = brake;
                        step_next = steps_next;
                        if (mem_we) rcnt_next = rcnt_reg + 1'b1;
                        if ((mem_we && (rcnt_reg + 1'b1 >= RC'(READINGS)))
                            || (rcnt_reg >= RC'(READINGS)) || steps_next >= COLLECT_STEPS) begin
                            idx_reg <= '0;
                            sum_reg <= '0;
                            rd_lag_reg <= 1'b0;
                            st_next = S_SUM;
                        end
                    end
                    m_data   <= out_next;
                    st_reg   <= st_next;
                    ph_reg   <= ph_next;
                    step_reg <= step_next;
                    rcnt_reg <= rcnt_next;
                    tmo_reg  <= tmo_next;
                end
                S_WMIN: begin
                    // one window entry per cycle
                    if (widx_reg == '0) begin
                        lo_reg <= win_reg[0]; hi_reg <= win_reg[0];
                    end else begin
                        if (win_reg[widx_reg] < lo_reg) lo_reg <= win_reg[widx_reg];
                        if (win_reg[widx_reg] > hi_reg) hi_reg <= win_reg[widx_reg];
                    end
                    if (32'(widx_reg) == WINDOW_LEN - 1) st_reg <= S_WTEST;
                    widx_reg <= widx_reg + 1'b1;
                end
                S_WTEST: begin
                    st_reg <= S_OUT;
                    if (still) begin
                        tmo_reg <= 1'b0; ph_reg <= PH_COLLECT;
                        step_reg <= '0; rcnt_reg <= '0;
                    end else if (step_reg >= SETTLE_STEPS) begin
                        tmo_reg <= 1'b1; ph_reg <= PH_COLLECT;
                        step_reg <= '0; rcnt_reg <= '0;
                    end
                end
                S_SUM: begin
                    // the read data is registered, so it follows its address in the next cycle
                    if (rd_lag_reg) sum_reg <= sum_reg + 23'(rd_val);
                    rd_lag_reg <= idx_reg < rcnt_reg;
                    if (idx_reg < rcnt_reg) idx_reg <= idx_reg + 1'b1;
                    else if (!rd_lag_reg) st_reg <= S_DIVSET;
                end
                S_DIVSET: begin
                    ph_reg <= PH_IDLE;
                    m_data.done_res <= 1'b1;
                    m_data.final_speed <= it_reg.speed;
                    m_data.status <= (rcnt_reg == '0) ? ST_NOREAD
                                   : (tmo_reg ? ST_TIMEOUT : ST_SETTLED);
                    if (rcnt_reg == '0) begin
                        st_reg <= S_OUT;
                    end else begin
                        neg_reg <= sum_reg[22];
                        dvd_reg <= sum_reg[22] ? 23'(-sum_reg) : 23'(sum_reg);
                        den_reg <= 16'(rcnt_reg);
                        rem_reg <= '0; quo_reg <= '0;
                        bit_reg <= 5'd22;
                        ratio_mode_reg <= 1'b0;
                        st_reg <= S_DIV;
                    end
                end
                S_DIV: begin
                    // restoring divide, one quotient bit per cycle
                    logic [23:0] r;
                    r = {rem_reg, dvd_reg[bit_reg]};
                    if (r >= 24'(den_reg)) begin
                        rem_reg <= 23'(r - 24'(den_reg));
                        quo_reg[bit_reg] <= 1'b1;
                    end else begin
                        rem_reg <= r[22:0];
                    end
                    if (bit_reg == 5'd0) st_reg <= ratio_mode_reg ? S_RDIV : S_POW1;
                    bit_reg <= bit_reg - 1'b1;
                end
                S_POW1: begin
                    logic signed [16:0] mq;
                    mq = neg_reg ? -17'(quo_reg) : 17'(quo_reg);
                    mean_reg <= mq;
                    m_data.mean_torque <= mq[15:0];
                    pneg_reg <= mq[16];
                    p_reg <= 37'(mq[16] ? 17'(-mq) : mq) * 37'(it_reg.speed);
                    st_reg <= S_POW2;
                end
                S_POW2: begin
                    // the full product fits without a cut: 37 bit by 21 bit into 58 bits
                    mag_reg <= 58'(p_reg) * 58'(POWER_Q32);
                    idx_reg <= '0; dev_reg <= '0; rd_lag_reg <= 1'b0;
                    st_reg <= S_DEV;
                end
                S_DEV: begin
                    if (rd_lag_reg && absd > dev_reg) dev_reg <= absd;
                    rd_lag_reg <= idx_reg < rcnt_reg;
                    if (idx_reg < rcnt_reg) idx_reg <= idx_reg + 1'b1;
                    else if (!rd_lag_reg) begin
                        logic [25:0] q;
                        logic signed [26:0] pw;
                        q  = mag_reg[57:32];
                        pw = pneg_reg ? -27'(q) : 27'(q);
                        if (pw > 27'sd8388607) pw = 27'sd8388607;
                        if (pw < -27'sd8388608) pw = -27'sd8388608;
                        m_data.power_watts <= pw[23:0];
                        dvd_reg <= 23'({dev_reg, 12'd0} >> 6);
                        st_reg <= S_RDIV;
                        ratio_mode_reg <= 1'b1;
                        bit_reg <= 5'd28;
                    end
                end
                S_RDIV: begin
                    // dev*4096/den, done bit-serially below
                    logic [28:0] nm;
                    logic [29:0] r;
                    nm = {dev_reg, 12'd0};
                    if (bit_reg == 5'd28 && ratio_mode_reg) begin
                        den_reg <= (mean_reg > 17'sd16) ? mean_reg[15:0] : 16'd16;
                        rem_reg <= '0; quo_reg <= '0;
                        ratio_mode_reg <= 1'b0;
                    end else begin
                        r = {6'd0, rem_reg, nm[bit_reg]};
                        if (r >= 30'(den_reg)) begin
                            rem_reg <= 23'(r - 30'(den_reg));
                            if (bit_reg < 5'd23) quo_reg[bit_reg] <= 1'b1;
                            else quo_reg <= '1;
                        end else begin
                            rem_reg <= r[22:0];
                        end
                        if (bit_reg == 5'd0) begin
                            st_reg <= S_OUT;
                            bit_reg <= 5'd31;
                        end else begin
                            bit_reg <= bit_reg - 1'b1;
                        end
                    end
                end
                S_OUT: begin
                    if (bit_reg == 5'd31) begin
                        m_data.spread_ratio <= (quo_reg > 23'd65535) ? 16'hFFFF : quo_reg[15:0];
                        bit_reg <= '0;
                    end else if (!m_valid) begin
                        m_data.phase <= ph_reg;
                        m_valid <= 1'b1;
                        st_reg <= S_IDLE;
                    end
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    `ASSERT_NEVER(a_phase_range, aclk, aresetn, ph_reg == 2'd3, "phase code 3")
    `ASSERT_IMPL(a_one_item, aclk, aresetn, (q_valid && q_ready) |=> !q_ready, "double accept")
    `ASSERT_IMPL(a_fill_cap, aclk, aresetn, (fill_reg <= FW'(WINDOW_LEN)), "window overfill")
    `ASSERT_IMPL(a_rcnt_cap, aclk, aresetn, (rcnt_reg <= RC'(READINGS)), "store overfill")
endmodule

[hdl/dyno_speed_hold_and_torque_average_unit.sv]
// top level of the dyno speed hold and torque average unit
`timescale 1ns / 1ps
// path: a plain sample beat takes the control step only, the window test adds a min/max pass,
// and a completing beat with a full store adds sum, two serial dividers and a deviation pass
// flow: the back end takes one beat at a time and accepts the next only once its result is taken;
// a two beat queue decouples input
// reset: synchronous active low aresetn, control and configuration registers return to their defaults, idle phase
module dyno_speed_hold_and_torque_average_unit import dsh_pkg::*; #(
    parameter int WINDOW_LEN = 8,
    parameter int READINGS   = 20
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  dsh_in_t     s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output dsh_out_t    m_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    logic     q_valid, q_ready;
    dsh_in_t  q_data;
    dsh_cfg_t cfg;

    // front end buffers beats and holds configuration
    dsh_front u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data,
        .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
        .q_valid, .q_ready, .q_data, .cfg
    );

    // back end runs one beat to completion
    dsh_back #(.WINDOW_LEN(WINDOW_LEN), .READINGS(READINGS)) u_back (
        .aclk, .aresetn, .q_valid, .q_ready, .q_data, .cfg,
        .m_valid, .m_ready, .m_data
    );
endmodule

[bench/dsh_scoreboard.sv]
// checker for the dyno speed hold unit: watches the channels, predicts and compares results
`timescale 1ns / 1ps
module dsh_scoreboard import dsh_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  dsh_in_t     s_data,
    input  logic        m_valid,
    input  logic        m_ready,
    input  dsh_out_t    m_data,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int          fail_count,
    output int          pending
);
    localparam int WIN_LEN = 8;
    localparam int N_READ  = 20;

    // register copies
    int tgt, ovr, swin, gain, tol, blow, bhigh;

    // controller state
    logic [1:0] run_ph;
    int         torq_win [WIN_LEN];
    int         fill, slot;
    int         store [N_READ];
    int         nread, steps, last_brake;
    bit         timed_out;

    dsh_out_t   expected_q [$];

    function automatic int brake_step(dsh_in_t b);
        longint prod, bv;
        prod = (longint'(b.speed) - longint'(tgt)) * longint'(gain);
        bv = longint'(b.torque) + (prod >>> 8);
        if (bv < blow) bv = blow;
        if (bv > bhigh) bv = bhigh;
        last_brake = int'(bv);
        steps++;
        return last_brake;
    endfunction

    function automatic bit window_quiet();
        int lo, hi;
        lo = torq_win[0];
        hi = torq_win[0];
        for (int i = 1; i < WIN_LEN; i++) begin
            if (torq_win[i] < lo) lo = torq_win[i];
            if (torq_win[i] > hi) hi = torq_win[i];
        end
        return longint'(hi - lo) * 65536 < longint'(tol) * longint'(hi);
    endfunction

    function automatic void summarize(ref dsh_out_t r, input int spd);
        longint sum, mean, p, q, pw, dev, d, den, ratio;
        logic [63:0] mag;
        logic [1:0] st;
        sum = 0; mean = 0; pw = 0; dev = 0; ratio = 0;
        st = timed_out ? ST_TIMEOUT : ST_SETTLED;
        if (nread == 0) begin
            st = ST_NOREAD;
        end else begin
            for (int i = 0; i < nread; i++) sum += store[i];
            mean = sum / nread;
            p = mean * spd;
            mag = (p < 0 ? -p : p) * 64'd1756906;
            q = longint'(mag >> 32);
            pw = p < 0 ? -q : q;
            if (pw > 8388607) pw = 8388607;
            if (pw < -8388608) pw = -8388608;
            for (int i = 0; i < nread; i++) begin
                d = store[i] - mean;
                if (d < 0) d = -d;
                if (d > dev) dev = d;
            end
            den = mean > 16 ? mean : 16;
            ratio = dev * 4096 / den;
            if (ratio > 65535) ratio = 65535;
        end
        r.done_res     = 1'b1;
        r.status       = st;
        r.final_speed  = spd[19:0];
        r.mean_torque  = mean[15:0];
        r.power_watts  = pw[23:0];
        r.spread_ratio = ratio[15:0];
        run_ph = PH_IDLE;
    endfunction

    function automatic dsh_out_t next_command(dsh_in_t b);
        dsh_out_t r;
        int brake;
        bit settled;
        longint e;
        r = '0;
        r.throttle_open = (b.speed > ovr) ? 1'b0 : 1'b1;
        brake = last_brake;
        if (b.req_type) begin
            run_ph = PH_SETTLE;
            fill = 0; slot = 0; nread = 0; steps = 0; timed_out = 0;
        end else if (run_ph == PH_SETTLE) begin
            settled = 0;
            brake = brake_step(b);
            if (b.cycle_done) begin
                torq_win[slot] = b.torque;
                slot = (slot + 1 >= WIN_LEN) ? 0 : slot + 1;
                if (fill < WIN_LEN) fill++;
                if (fill >= WIN_LEN) begin
                    e = longint'(b.speed) - tgt;
                    if (e < 0) e = -e;
                    if (e <= swin && window_quiet()) settled = 1;
                end
            end
            if (settled || steps >= int'(SETTLE_STEPS)) begin
                timed_out = !settled;
                run_ph = PH_COLLECT; steps = 0; nread = 0;
            end
        end else if (run_ph == PH_COLLECT) begin
            brake = brake_step(b);
            if (b.cycle_done && nread < N_READ) begin
                store[nread] = b.torque;
                nread++;
            end
            if (nread >= N_READ || steps >= int'(COLLECT_STEPS)) summarize(r, b.speed);
        end
        r.brake_command = brake[15:0];
        r.phase = run_ph;
        return r;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    task automatic compare_result(dsh_out_t got, dsh_out_t want);
        if (got.brake_command !== want.brake_command)
            report("brake_command", got.brake_command, want.brake_command);
        if (got.throttle_open !== want.throttle_open)
            report("throttle_open", got.throttle_open, want.throttle_open);
        if (got.phase !== want.phase) report("phase", got.phase, want.phase);
        if (got.done_res !== want.done_res) report("done_res", got.done_res, want.done_res);
        if (got.status !== want.status) report("status", got.status, want.status);
        if (got.final_speed !== want.final_speed)
            report("final_speed", got.final_speed, want.final_speed);
        if (got.mean_torque !== want.mean_torque)
            report("mean_torque", got.mean_torque, want.mean_torque);
        if (got.power_watts !== want.power_watts)
            report("power_watts", got.power_watts, want.power_watts);
        if (got.spread_ratio !== want.spread_ratio)
            report("spread_ratio", got.spread_ratio, want.spread_ratio);
    endtask

    initial fail_count = 0;
    assign pending = expected_q.size();

    always @(posedge aclk) begin
        if (!aresetn) begin
            tgt = 16000; ovr = 105600; swin = 400; gain = 154; tol = 262;
            blow = -2400; bhigh = 19200;
            run_ph = PH_IDLE; fill = 0; slot = 0; nread = 0; steps = 0;
            last_brake = 0; timed_out = 0;
            expected_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_TARGET:    tgt = cfg_data[19:0];
                    REG_OVERSPEED: ovr = cfg_data[19:0];
                    REG_WINDOW:    swin = cfg_data[15:0];
                    REG_GAIN:      gain = cfg_data[9:0];
                    REG_TOL:       tol = cfg_data[15:0];
                    REG_BLOW:      blow = int'($signed(cfg_data[15:0]));
                    REG_BHIGH:     bhigh = cfg_data[14:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                expected_q.insert(expected_q.size(), next_command(s_data));
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    $display("%0t result beat with nothing expected", $realtime);
                    fail_count++;
                end else begin
                    compare_result(m_data, expected_q[0]);
                    expected_q.delete(0);
                end
            end
        end
    end
endmodule

[bench/dyno_speed_hold_and_torque_average_unit_tb.sv]
// top of the dyno speed hold unit testbench: stimulus, receiver stalls and verdict
`timescale 1ns / 1ps
module dyno_speed_hold_and_torque_average_unit_tb;
    import dsh_pkg::*;

    localparam int ITEMS      = 400;
    localparam int IDLE_LIMIT = 20000;  // cycles without any accepted beat
    localparam int DRAIN      = 200;    // extra wait after the last result has arrived

    logic        aclk;
    logic        aresetn;
    logic        s_valid, s_ready;
    dsh_in_t     s_data;
    logic        m_valid, m_ready;
    dsh_out_t    m_data;
    logic        cfg_valid, cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    int          fail_count, pending;

    // stimulus bookkeeping
    int sent;
    int burst_left;
    bit hold_req, hold_done;
    int idle_cycles;
    // shadow of the speed settings, used to aim samples near the target
    int tgt_cur, win_cur;

    dyno_speed_hold_and_torque_average_unit u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    dsh_scoreboard u_check (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending)
    );

    always begin
        aclk = 1'b1; #5;
        aclk = 1'b0; #5;
    end

    // watchdog: any accepted beat on any channel clears the count
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // receiver: random stall styles taken in turn, plus one long hold-off on request
    initial begin
        int mode, cnt;
        m_ready = 1'b0;
        mode = 0;
        cnt = 0;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_req && !hold_done) begin
                m_ready <= 1'b0;
                repeat (400) @(posedge aclk);
                hold_done = 1;
            end else begin
                if (cnt % 64 == 0) mode = $urandom_range(0, 3);
                cnt++;
                case (mode)
                    0: m_ready <= 1'b1;                           // no stalls
                    1: m_ready <= $urandom_range(0, 1);           // coin flip
                    2: m_ready <= (cnt % 4) != 0;                 // three of four
                    default: m_ready <= $urandom_range(0, 7) == 0; // mostly stalled
                endcase
                @(posedge aclk);
            end
        end
    end

    function automatic dsh_in_t beat(bit req, int spd, int trq, bit cyc);
        dsh_in_t b;
        b.req_type   = req;
        b.speed      = spd[19:0];
        b.torque     = trq[15:0];
        b.cycle_done = cyc;
        return b;
    endfunction

    // one input beat; bursts of random length with random gaps between them
    task automatic send_beat(dsh_in_t b);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 5) == 0) ? 60 : $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data  <= b;
        do @(posedge aclk); while (!s_ready);
        sent++;
        if (sent == 150) hold_req = 1;
    endtask

    // stop offering, let every result arrive, then let the back end settle
    task automatic drain();
        s_valid <= 1'b0;
        burst_left = 0;
        wait (pending == 0);
        repeat (DRAIN) @(posedge aclk);
    endtask

    task automatic write_regs(int t, int o, int w, int g, int tl, int bl, int bh);
        int vals [7];
        vals = '{t, o, w, g, tl, bl, bh};
        for (int i = 0; i < 7; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= i[2:0];
            cfg_data  <= vals[i];
            do @(posedge aclk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        tgt_cur = t;
        win_cur = w;
    endtask

    task automatic pick_settings();
        case ($urandom_range(0, 5))
            0: write_regs(0, 0, 65535, 1023, 65535, -32768, 0);
            1: write_regs(1048575, 1048575, 0, 0, 0, 0, 32767);
            2: write_regs(16000, 105600, 400, 154, 262, -2400, 19200);
            default: write_regs($urandom_range(8000, 120000), $urandom_range(0, 1048575),
                                $urandom_range(20, 3000), $urandom_range(0, 1023),
                                $urandom_range(100, 4000), -$urandom_range(0, 32768),
                                $urandom_range(0, 32767));
        endcase
    endtask

    function automatic int near_speed(int spread);
        int s;
        s = tgt_cur + $urandom_range(0, 2 * spread) - spread;
        if (s < 0) s = 0;
        if (s > 1048575) s = 1048575;
        return s;
    endfunction

    // start, samples aimed at settling, then the collection samples
    task automatic run_measurement();
        int base, jit, n_settle, n_collect;
        base = ($urandom_range(0, 7) == 0) ? -$urandom_range(0, 32768)
                                             : $urandom_range(32, 32000);
        jit = $urandom_range(0, 3);
        n_settle = $urandom_range(8, 14);
        n_collect = $urandom_range(20, 26);
        send_beat(beat(1'b1, near_speed(win_cur), base, 1'b0));
        for (int i = 0; i < n_settle + n_collect; i++) begin
            // an occasional early start aborts the measurement
            if ($urandom_range(0, 150) == 0) begin
                send_beat(beat(1'b1, near_speed(win_cur), base, 1'b1));
                break;
            end
            send_beat(beat(1'b0,
                           ($urandom_range(0, 9) == 0) ? near_speed(4 * win_cur + 10)
                                                       : near_speed(win_cur),
                           i < n_settle ? base + $urandom_range(0, jit)
                                        : base + $urandom_range(0, 2000) - 1000,
                           $urandom_range(0, 9) != 0));
        end
    endtask

    initial begin
        int n_meas;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_TARGET;
        cfg_data  = '0;
        sent = 0; burst_left = 0; hold_req = 0; hold_done = 0; idle_cycles = 0;
        tgt_cur = 16000; win_cur = 400;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        write_regs(16000, 105600, 400, 154, 262, -2400, 19200);

        // directed: idle samples at the field extremes, throttle compare both ways
        send_beat(beat(1'b0, 0, -32768, 1'b0));
        send_beat(beat(1'b0, 1048575, 32767, 1'b1));
        // negative window maximum never settles; then a start aborts it
        send_beat(beat(1'b1, 16000, 0, 1'b0));
        for (int i = 0; i < 9; i++) send_beat(beat(1'b0, 16000, -500 - i, 1'b1));
        send_beat(beat(1'b0, 1048575, 32767, 1'b0));     // clamps high
        send_beat(beat(1'b0, 0, -32768, 1'b1));          // clamps low
        // quiet torque at target speed settles, then collection completes
        send_beat(beat(1'b1, 16000, 3200, 1'b1));
        for (int i = 0; i < 8; i++) send_beat(beat(1'b0, 16000 + i, 3200, 1'b1));
        for (int i = 0; i < 22; i++) send_beat(beat(1'b0, 16010, 3000 + 30 * i, i != 3));
        drain();

        // extremes of the settings, with a measurement under each
        write_regs(0, 0, 65535, 1023, 65535, -32768, 0);
        run_measurement();
        drain();
        write_regs(1048575, 1048575, 0, 0, 0, 0, 32767);
        run_measurement();
        drain();

        // random part: mostly well-formed measurements, some noise
        n_meas = 0;
        while (sent < ITEMS) begin
            if (n_meas % 3 == 2) begin
                drain();
                pick_settings();
            end
            n_meas++;
            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, 8))
                    send_beat(beat($urandom_range(0, 7) == 0, $urandom_range(0, 1048575),
                                   $urandom_range(0, 65535), $urandom_range(0, 1)));
            end else begin
                run_measurement();
            end
        end
        drain();

        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
